// ===== sv/bfs_pkg.sv =====
// Shared types and constants for the bit frame serializer.
// No dependencies; imported by every module of the block.
package bfs_pkg;

  localparam int unsigned STR_W = 14;  // longest bit string of one request
  localparam int unsigned CNT_W = 4;   // holds 0..STR_W

  localparam logic [15:0]      PRE_RESET  = 16'd2400;
  localparam logic [15:0]      TAIL_ZEROS = 16'd16;
  localparam logic [2:0]       SYNC_EVERY = 3'd7;   // count at which a sync follows
  // sent LSB first: 1,0 then 0,0,1,0
  localparam logic [5:0]       HEAD_BITS  = 6'b010001;
  // sent LSB first: 0,0,1,0
  localparam logic [3:0]       SYNC_BITS  = 4'b0100;
  localparam logic [CNT_W-1:0] CNT_FIRST  = 4'd14;
  localparam logic [CNT_W-1:0] CNT_SYNC   = 4'd12;
  localparam logic [CNT_W-1:0] CNT_PLAIN  = 4'd8;

  typedef struct packed {
    logic             pre;      // preamble run pending
    logic [15:0]      pre_len;
    logic [STR_W-1:0] sbits;    // short bit string, bit 0 goes first
    logic [CNT_W-1:0] scnt;
    logic             tail;     // sixteen trailing zeros
  } bfs_entry_t;

endpackage

// ===== sv/bfs_in_if.sv =====
// Input byte channel: valid/ready plus the message byte and its flags.
// No dependencies.
interface bfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

// ===== sv/bfs_out_if.sv =====
// Output run channel: valid/ready plus one run of the line bit stream.
// No dependencies.
interface bfs_out_if;
  logic        valid;
  logic        ready;
  logic        bit_value;
  logic [15:0] run_length;
  logic        final_of_item;

  modport source (output valid, bit_value, run_length, final_of_item, input ready);
  modport sink   (input valid, bit_value, run_length, final_of_item, output ready);
endinterface

// ===== sv/bfs_cfg_if.sv =====
// Configuration write channel: valid/ready plus the preamble length.
// No dependencies.
interface bfs_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/bit_frame_serializer_unit.sv =====
// Channel   Dir  Payload                                   Accept
// in_i      in   data_byte[8], first_byte, last_byte        valid & ready
// out_o     out  bit_value, run_length[16], final_of_item   valid & ready
// cfg_i     in   data[16] (preamble zero count)             valid & ready
//
// One request yields 1..13 runs, emitted one per cycle by the back end while
// the output register is not held; the front end builds each request
// combinationally and runs ahead through a two-entry queue.
// Reset clears the queue, the sync byte count and the output valid flag and
// sets the preamble length to 2400. The input stalls only when the queue is
// full; the back end stalls only while the output register is held.
// Depends on bfs_pkg, bfs_in_if, bfs_out_if, bfs_cfg_if, bfs_front,
// bfs_queue and bfs_back.
module bit_frame_serializer_unit import bfs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bfs_in_if.sink    in_i,
  bfs_cfg_if.sink   cfg_i,
  bfs_out_if.source out_o
);

  logic       q_push, q_full, q_pop, q_valid;
  bfs_entry_t f_ent, q_ent;

  bfs_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .full_i (q_full),
    .push_o (q_push),
    .ent_o  (f_ent)
  );

  bfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .ent_i   (f_ent),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .ent_o   (q_ent)
  );

  bfs_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .ent_i   (q_ent),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

  a_pop_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("push into full queue");

  a_one_run_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.bit_value) |-> (out_o.run_length <= 16'd8))
    else $error("run of ones too long");

  a_final_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.final_of_item) |->
      (out_o.run_length != 16'd0 && out_o.run_length <= 16'd30))
    else $error("bad final run length");

endmodule

// ===== sv/bfs_front.sv =====
// Front end: accepts byte requests, tracks the sync spacing and builds
// the bit string of each request. Depends on bfs_pkg, bfs_in_if, bfs_cfg_if.
module bfs_front import bfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfs_in_if.sink     in_i,
  bfs_cfg_if.sink    cfg_i,
  input  logic       full_i,
  output logic       push_o,
  output bfs_entry_t ent_o
);

  logic [15:0] pre_q;
  logic [2:0]  bss_q, bss_d, bss_eff;
  logic        sync_after;

  assign in_i.ready  = !full_i;
  assign cfg_i.ready = 1'b1;
  assign push_o      = in_i.valid && in_i.ready;

  always_comb begin
    bss_eff    = in_i.first_byte ? 3'd0 : bss_q;
    sync_after = (bss_eff == SYNC_EVERY);

    ent_o.pre     = in_i.first_byte && (pre_q != 16'd0);
    ent_o.pre_len = pre_q;
    ent_o.tail    = in_i.last_byte;
    if (in_i.first_byte) begin
      ent_o.sbits = {in_i.data_byte, HEAD_BITS};
      ent_o.scnt  = CNT_FIRST;
    end else if (sync_after) begin
      ent_o.sbits = {2'b00, SYNC_BITS, in_i.data_byte};
      ent_o.scnt  = CNT_SYNC;
    end else begin
      ent_o.sbits = {6'b000000, in_i.data_byte};
      ent_o.scnt  = CNT_PLAIN;
    end

    bss_d = bss_q;
    if (push_o) begin
      if (in_i.last_byte || sync_after) begin
        bss_d = 3'd0;
      end else begin
        bss_d = bss_eff + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q <= PRE_RESET;
      bss_q <= 3'd0;
    end else begin
      bss_q <= bss_d;
      if (cfg_i.valid && cfg_i.ready) begin
        pre_q <= cfg_i.data;
      end
    end
  end

endmodule

// ===== sv/bfs_queue.sv =====
// Two-entry queue of built requests between front and back end.
// Depends on bfs_pkg.
module bfs_queue import bfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  bfs_entry_t ent_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output bfs_entry_t ent_o
);

  bfs_entry_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign ent_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== sv/bfs_back.sv =====
// Back end: walks one request at a time and emits one merged run per cycle,
// unless the output register is held, into an output register. Depends on bfs_pkg, bfs_out_if.
module bfs_back import bfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  bfs_entry_t ent_i,
  output logic       pop_o,
  bfs_out_if.source  out_o
);

  logic             busy_q, pre_q, tail_q;
  logic [15:0]      pre_len_q;
  logic [STR_W-1:0] sbits_q;
  logic [CNT_W-1:0] scnt_q;
  logic             ovalid_q, obit_q, ofinal_q;
  logic [15:0]      olen_q;

  logic             b, stop, take_all, advance, done;
  logic [CNT_W-1:0] n;
  logic             rbit, rfinal;
  logic [15:0]      rlen;

  // length of the leading run of equal bits in the string, then the run to emit: preamble, tail or string run
  always_comb begin
    b    = sbits_q[0];
    n    = CNT_W'(1);
    stop = 1'b0;
    for (int i = 1; i < STR_W; i++) begin
      if (!stop && (CNT_W'(i) < scnt_q) && (sbits_q[i] == b)) begin
        n = n + CNT_W'(1);
      end else begin
        stop = 1'b1;
      end
    end
    take_all = (n == scnt_q);

    if (pre_q) begin
      rbit   = 1'b0;
      rlen   = pre_len_q;
      rfinal = 1'b0;
    end else if (scnt_q == '0) begin
      rbit   = 1'b0;
      rlen   = TAIL_ZEROS;
      rfinal = 1'b1;
    end else begin
      rbit   = b;
      rlen   = 16'(n);
      rfinal = take_all && !(tail_q && b);
      if (take_all && tail_q && !b) begin
        rlen = 16'(n) + TAIL_ZEROS;  // trailing zeros merge into last run
      end
    end
  end

  assign advance = busy_q && (!ovalid_q || out_o.ready);
  assign done    = advance && rfinal;
  assign pop_o   = valid_i && (!busy_q || done);

  assign out_o.valid         = ovalid_q;
  assign out_o.bit_value     = obit_q;
  assign out_o.run_length    = olen_q;
  assign out_o.final_of_item = ofinal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      pre_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        pre_q  <= ent_i.pre;
      end else begin
        if (done) busy_q <= 1'b0;
        if (advance) pre_q <= 1'b0;
      end
      if (advance) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pre_len_q <= ent_i.pre_len;
      sbits_q   <= ent_i.sbits;
      scnt_q    <= ent_i.scnt;
      tail_q    <= ent_i.tail;
    end else if (advance && !pre_q && scnt_q != '0) begin
      sbits_q <= sbits_q >> n;
      scnt_q  <= scnt_q - n;
    end
    if (advance) begin
      obit_q   <= rbit;
      olen_q   <= rlen;
      ofinal_q <= rfinal;
    end
  end

endmodule
